// ===== sv/pixel_to_occupancy_classifier_core_macros.svh =====
// Assertion macros shared by the pixel to occupancy classifier RTL.
`ifndef PIXEL_TO_OCCUPANCY_CLASSIFIER_CORE_MACROS_SVH
`define PIXEL_TO_OCCUPANCY_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define P2OC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("p2oc assertion failed");
`define P2OC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("p2oc assertion failed");
`else
`define P2OC_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define P2OC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/p2oc_pkg.sv =====
// Types and constants of the pixel to occupancy classifier.
package p2oc_pkg;

	localparam int DIM_W  = 13;
	localparam int IDX_W  = 24;
	localparam int NUM_W  = 32;
	localparam int DEN_W  = 25;
	localparam int DIV_QW = 7;

	localparam logic [1:0] MODE_TRINARY = 2'd0;
	localparam logic [1:0] MODE_SCALED  = 2'd1;
	localparam logic [1:0] MODE_RAW     = 2'd2;

	localparam logic [7:0] RED_FREE_MIN   = 8'd245;
	localparam logic [7:0] BLUE_FREE_MIN  = 8'd226;
	localparam logic [7:0] SCALE_SPAN     = 8'd98;
	localparam logic [7:0] VAL_FREE       = 8'd0;
	localparam logic [7:0] VAL_OCC        = 8'd100;
	localparam logic [7:0] VAL_UNKNOWN    = 8'd255;
	localparam logic [7:0] VAL_SCALED_MIN = 8'd1;
	localparam logic [7:0] VAL_SCALED_MAX = 8'd99;
	localparam logic [8:0] FULL_SCALE2    = 9'd510;

	localparam logic [1:0]       RST_MAP_MODE = MODE_TRINARY;
	localparam logic [15:0]      RST_OCC_THR  = 16'd42598;
	localparam logic [15:0]      RST_FREE_THR = 16'd12845;
	localparam logic [2:0]       RST_CHAN_CNT = 3'd1;
	localparam logic [DIM_W-1:0] RST_DIM      = 13'd4096;

	typedef enum logic [2:0] {
		REG_MAP_MODE,
		REG_NEGATE,
		REG_OCC_THR,
		REG_FREE_THR,
		REG_CHAN_CNT,
		REG_ALPHA,
		REG_WIDTH,
		REG_HEIGHT
	} p2oc_reg_t;

	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
	} p2oc_pixel_t;

	typedef struct packed {
		logic [IDX_W-1:0] cell_index;
		logic [7:0]       cell_value;
		logic             last_cell;
	} p2oc_cell_t;

	typedef struct packed {
		p2oc_reg_t   addr;
		logic [15:0] wdata;
	} p2oc_cfg_t;

	typedef struct packed {
		logic [1:0]       map_mode;
		logic             negate;
		logic [15:0]      occ_thr;
		logic [15:0]      free_thr;
		logic [2:0]       chan_cnt;
		logic             alpha;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} p2oc_settings_t;

endpackage

// ===== sv/p2oc_ifs.sv =====
// Valid/ready channel interfaces for pixels, cells and configuration writes.
interface p2oc_pix_if;
	import p2oc_pkg::*;
	logic        valid;
	logic        ready;
	p2oc_pixel_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface p2oc_cell_if;
	import p2oc_pkg::*;
	logic       valid;
	logic       ready;
	p2oc_cell_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface p2oc_cfg_if;
	import p2oc_pkg::*;
	logic      valid;
	logic      ready;
	p2oc_cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/p2oc_cfg_regs.sv =====
// Configuration register file of the pixel to occupancy classifier.
module p2oc_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	p2oc_cfg_if.sink                 cfg,
	output p2oc_pkg::p2oc_settings_t settings
);
	import p2oc_pkg::*;

	p2oc_settings_t settings_q;

	assign cfg.ready = 1'b1;
	assign settings  = settings_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_q.map_mode <= RST_MAP_MODE;
			settings_q.negate   <= 1'b0;
			settings_q.occ_thr  <= RST_OCC_THR;
			settings_q.free_thr <= RST_FREE_THR;
			settings_q.chan_cnt <= RST_CHAN_CNT;
			settings_q.alpha    <= 1'b0;
			settings_q.width    <= RST_DIM;
			settings_q.height   <= RST_DIM;
		end else if (cfg.valid) begin
			unique case (cfg.data.addr)
				REG_MAP_MODE: settings_q.map_mode <= cfg.data.wdata[1:0];
				REG_NEGATE:   settings_q.negate   <= cfg.data.wdata[0];
				REG_OCC_THR:  settings_q.occ_thr  <= cfg.data.wdata;
				REG_FREE_THR: settings_q.free_thr <= cfg.data.wdata;
				REG_CHAN_CNT: settings_q.chan_cnt <= cfg.data.wdata[2:0];
				REG_ALPHA:    settings_q.alpha    <= cfg.data.wdata[0];
				REG_WIDTH:    settings_q.width    <= cfg.data.wdata[DIM_W-1:0];
				REG_HEIGHT:   settings_q.height   <= cfg.data.wdata[DIM_W-1:0];
				default:      settings_q          <= settings_q;
			endcase
		end
	end

endmodule

// ===== sv/p2oc_raster.sv =====
// Raster position counters and vertically flipped cell index.
module p2oc_raster #(
	parameter int MAX_DIM = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  p2oc_pkg::p2oc_settings_t settings,
	input  logic                     advance,
	output logic [p2oc_pkg::IDX_W-1:0] cell_index,
	output logic                     last_cell
);
	import p2oc_pkg::*;

	localparam int CNT_W = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W;
	localparam int PRD_W = 2 * DIM_W;

	logic [CNT_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] dim_w, dim_h;
	logic [DIM_W-1:0] col_eff, row_eff, col_inc, row_inc, rows_left;
	logic [PRD_W-1:0] idx_sum;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	always_comb begin
		dim_w     = clamp_dim(settings.width);
		dim_h     = clamp_dim(settings.height);
		col_eff   = (DIM_W'(col_q) >= dim_w) ? '0 : DIM_W'(col_q);
		row_eff   = (DIM_W'(row_q) >= dim_h) ? '0 : DIM_W'(row_q);
		col_inc   = col_eff + DIM_W'(1);
		row_inc   = row_eff + DIM_W'(1);
		rows_left = dim_h - DIM_W'(1) - row_eff;
		idx_sum   = PRD_W'(dim_w) * PRD_W'(rows_left) + PRD_W'(col_eff);
	end

	assign cell_index = idx_sum[IDX_W-1:0];
	assign last_cell  = (col_inc == dim_w) && (row_inc == dim_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= dim_w) begin
				col_q <= '0;
				row_q <= (row_inc >= dim_h) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
				row_q <= row_eff[CNT_W-1:0];
			end
		end
	end

endmodule

// ===== sv/p2oc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the scaled occupancy ratio.
module p2oc_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [p2oc_pkg::NUM_W-1:0]    num,
	input  logic [p2oc_pkg::DEN_W-1:0]    den,
	output logic                          done,
	output logic [p2oc_pkg::DIV_QW-1:0]   quot
);
	import p2oc_pkg::*;

	localparam int CNT_W = $clog2(DIV_QW);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q, den_sh_q;
	logic [DIV_QW-1:0] quot_q;
	logic             fits;

	assign fits = (rem_q >= den_sh_q);
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= CNT_W'(DIV_QW - 1);
				rem_q    <= num;
				den_sh_q <= NUM_W'(den) << (DIV_QW - 1);
				quot_q   <= '0;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - den_sh_q;
				end
				quot_q   <= {quot_q[DIV_QW-2:0], fits};
				den_sh_q <= den_sh_q >> 1;
				cnt_q    <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/pixel_to_occupancy_classifier_core.sv =====
// Top level of the pixel to occupancy classifier: sequencer and classification.
// Sequence: a pixel accepted in ST_IDLE is classified in ST_PREP and written to the output
// register in ST_FIN; scaled cells pass through ST_LOAD and ST_DIV first, where the restoring
// divider forms the 7-bit quotient one bit at a time. A new pixel is taken only in ST_IDLE,
// even while a finished cell still waits in the output register.
// Reset: clears the sequencer, the raster counters and the output valid, and loads the
// configuration reset values. No clearing pass.
`include "pixel_to_occupancy_classifier_core_macros.svh"

module pixel_to_occupancy_classifier_core #(
	parameter int MAX_DIM = 4096
) (
	input logic         clk,
	input logic         arst_n,
	p2oc_pix_if.sink    pix,
	p2oc_cell_if.source grid,
	p2oc_cfg_if.sink    cfg
);
	import p2oc_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_LOAD, ST_DIV, ST_FIN} state_t;

	state_t           state_q;
	p2oc_settings_t   settings;
	p2oc_pixel_t      pix_q;
	logic [IDX_W-1:0] idx_q, r_idx;
	logic             last_q, r_last;
	logic [7:0]       value_q;
	logic [DEN_W-1:0] diff_q, den_q;
	logic             out_valid_q;
	logic             out_stall;
	p2oc_cell_t       out_q;
	logic             div_done;
	logic [DIV_QW-1:0] div_quot;
	logic             accept;

	logic [2:0]       n_ch, k_ch;
	logic [8:0]       m2, m2n, d_occ;
	logic [7:0]       alpha_byte;
	logic             alpha_zero;
	logic [DEN_W-1:0] lhs, othr, fthr, thr_gap;
	logic [15:0]      thr_dlt;
	logic [7:0]       prep_value;
	logic             need_div;
	logic [7:0]       scaled_inc, scaled_value;

	assign accept    = pix.valid && pix.ready;
	assign pix.ready = (state_q == ST_IDLE);
	assign grid.valid = out_valid_q;
	assign grid.data  = out_q;
	assign out_stall  = out_valid_q && !grid.ready;

	p2oc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings)
	);

	p2oc_raster #(
		.MAX_DIM (MAX_DIM)
	) u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.settings   (settings),
		.advance    (accept),
		.cell_index (r_idx),
		.last_cell  (r_last)
	);

	p2oc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LOAD),
		.num    (NUM_W'(diff_q) * NUM_W'(SCALE_SPAN)),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		n_ch = settings.chan_cnt;
		if (n_ch == 3'd0) begin
			n_ch = 3'd1;
		end else if (n_ch > 3'd4) begin
			n_ch = 3'd4;
		end
		k_ch = (settings.map_mode == MODE_TRINARY || !settings.alpha) ? n_ch : n_ch - 3'd1;
		if (k_ch == 3'd0) begin
			k_ch = 3'd1;
		end
		m2         = (k_ch == 3'd1) ? {pix_q.chan0, 1'b0} : 9'(pix_q.chan0) + 9'(pix_q.chan1);
		alpha_byte = (n_ch == 3'd2) ? pix_q.chan1 : pix_q.chan2;
		alpha_zero = (n_ch != 3'd1) && (alpha_byte == 8'd0);
		m2n        = settings.negate ? FULL_SCALE2 - m2 : m2;
		d_occ      = FULL_SCALE2 - m2n;
		lhs        = {d_occ, 16'd0};
		othr       = {settings.occ_thr, 9'd0} - DEN_W'({settings.occ_thr, 1'b0});
		fthr       = {settings.free_thr, 9'd0} - DEN_W'({settings.free_thr, 1'b0});
		thr_dlt    = settings.occ_thr - settings.free_thr;
		thr_gap    = {thr_dlt, 9'd0} - DEN_W'({thr_dlt, 1'b0});
		need_div   = 1'b0;
		if (k_ch > 3'd2) begin
			prep_value = (pix_q.chan0 >= RED_FREE_MIN || pix_q.chan2 >= BLUE_FREE_MIN) ?
				VAL_FREE : VAL_OCC;
		end else if (settings.map_mode == MODE_RAW) begin
			prep_value = m2n[8:1];
		end else if (lhs > othr) begin
			prep_value = VAL_OCC;
		end else if (lhs < fthr) begin
			prep_value = VAL_FREE;
		end else if (settings.map_mode == MODE_TRINARY || alpha_zero) begin
			prep_value = VAL_UNKNOWN;
		end else if (settings.occ_thr <= settings.free_thr) begin
			prep_value = VAL_SCALED_MIN;
		end else begin
			prep_value = VAL_SCALED_MIN;
			need_div   = 1'b1;
		end
		scaled_inc   = 8'(div_quot) + VAL_SCALED_MIN;
		scaled_value = (scaled_inc > VAL_SCALED_MAX) ? VAL_SCALED_MAX : scaled_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (grid.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pix.valid) begin
						pix_q   <= pix.data;
						idx_q   <= r_idx;
						last_q  <= r_last;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					diff_q  <= lhs - fthr;
					den_q   <= thr_gap;
					value_q <= prep_value;
					state_q <= need_div ? ST_LOAD : ST_FIN;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						value_q <= scaled_value;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || grid.ready) begin
						out_q.cell_index <= idx_q;
						out_q.cell_value <= value_q;
						out_q.last_cell  <= last_q;
						out_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`P2OC_ASSERT_IMPL(a_done_in_div, clk, arst_n, div_done, state_q == ST_DIV)
	`P2OC_ASSERT_IMPL(a_quot_range, clk, arst_n, div_done, div_quot <= DIV_QW'(SCALE_SPAN))
	`P2OC_ASSERT_NEXT(a_hold_result, clk, arst_n, state_q == ST_FIN && out_stall, state_q == ST_FIN)

endmodule
